FILE: design/pfjid_pkg.sv
// ----------------------------------------------------------------------------
// pfjid_pkg
// Shared constants, codes, snapshot type and saturating helpers for the
// particle-flow jet identification classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pfjid_pkg;

  // Sizes
  localparam int MAX_CONSTITUENTS = 256;
  localparam int SEEN_W  = $clog2(MAX_CONSTITUENTS + 1);
  localparam int ESUM_W  = 28;
  localparam int CNT_W   = 9;
  localparam int E_W     = 20;
  localparam int PT_W    = 16;
  localparam int ETA_W   = 10;
  localparam int BND_W   = 9;
  localparam int TIER_W  = 3;
  localparam int MINT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Product width for the fraction cuts: energy sum times a 7-bit constant
  localparam int MUL_W = ESUM_W + 7;

  localparam logic [ESUM_W-1:0] ESUM_MAX = {ESUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_PT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_BOUNDARY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIER     = 2'd2;

  // Configuration reset values
  localparam logic [PT_W-1:0]   BYPASS_PT_RST    = 16'd40;
  localparam logic [BND_W-1:0]  ETA_BOUNDARY_RST = 9'd240;
  localparam logic [MINT_W-1:0] MIN_TIER_RST     = 2'd1;

  // Particle kinds
  localparam logic [2:0] KIND_CHARGED     = 3'd1;
  localparam logic [2:0] KIND_ELECTRON    = 3'd2;
  localparam logic [2:0] KIND_PHOTON      = 3'd3;
  localparam logic [2:0] KIND_NEUTRAL     = 3'd4;
  localparam logic [2:0] KIND_FWD_HADRON  = 3'd5;
  localparam logic [2:0] KIND_FWD_EGAMMA  = 3'd6;

  // Result tiers
  localparam logic [TIER_W-1:0] TIER_FAIL   = 3'd0;
  localparam logic [TIER_W-1:0] TIER_LOOSE  = 3'd1;
  localparam logic [TIER_W-1:0] TIER_MEDIUM = 3'd2;
  localparam logic [TIER_W-1:0] TIER_TIGHT  = 3'd3;
  localparam logic [TIER_W-1:0] TIER_BYPASS = 3'd4;

  // Jet summary handed from the accumulator to the classifier
  typedef struct packed {
    logic              bypass;
    logic              fwd;
    logic              cen;
    logic              tot_zero;
    logic              chg_ok;
    logic              cnt_ok;
    logic [ESUM_W-1:0] neu_e;
    logic [ESUM_W-1:0] pho_e;
    logic [ESUM_W-1:0] ele_e;
    logic [ESUM_W-1:0] tot_e;
  } snap_t;

  // Energy sum that sticks at full scale
  function automatic logic [ESUM_W-1:0] sat_add(input logic [ESUM_W-1:0] acc,
                                                input logic [E_W-1:0] e);
    logic [ESUM_W:0] s;
    s = {1'b0, acc} + (ESUM_W + 1)'(e);
    return s[ESUM_W] ? ESUM_MAX : s[ESUM_W-1:0];
  endfunction

  // Count that sticks at full scale
  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: design/pfjid_accum.sv
// ----------------------------------------------------------------------------
// pfjid_accum
// Input word register, per-jet running sums and the jet snapshot register
// loaded on the last word of each jet.
// ----------------------------------------------------------------------------
`default_nettype none

module pfjid_accum (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_has_constituent,
  input  wire logic [2:0]                          in_particle_kind,
  input  wire logic [pfjid_pkg::E_W-1:0]           in_energy,
  input  wire logic [pfjid_pkg::PT_W-1:0]          in_jet_pt,
  input  wire logic signed [pfjid_pkg::ETA_W-1:0]  in_jet_eta,
  input  wire logic                                in_last,
  input  wire logic [pfjid_pkg::PT_W-1:0]          bypass_pt,
  input  wire logic [pfjid_pkg::BND_W-1:0]         eta_boundary,
  output logic                                     snap_valid,
  input  wire logic                                snap_ready,
  output pfjid_pkg::snap_t                         snap
);

  // Input word register
  logic                              s1_valid_r;
  logic                              s1_has_r;
  logic [2:0]                        s1_kind_r;
  logic [pfjid_pkg::E_W-1:0]         s1_energy_r;
  logic [pfjid_pkg::PT_W-1:0]        s1_pt_r;
  logic [pfjid_pkg::ETA_W-1:0]       s1_eta_r;
  logic                              s1_last_r;

  // Running sums
  logic [pfjid_pkg::ESUM_W-1:0] chg_e_r, pho_e_r, neu_e_r, ele_e_r, tot_e_r;
  logic [pfjid_pkg::CNT_W-1:0]  cnt_r, chg_cnt_r;
  logic [pfjid_pkg::SEEN_W-1:0] seen_r;

  logic [pfjid_pkg::ESUM_W-1:0] chg_e_nxt, pho_e_nxt, neu_e_nxt, ele_e_nxt, tot_e_nxt;
  logic [pfjid_pkg::CNT_W-1:0]  cnt_nxt, chg_cnt_nxt;
  logic [pfjid_pkg::SEEN_W-1:0] seen_nxt;

  // Snapshot register
  logic             snap_valid_r;
  pfjid_pkg::snap_t snap_r;
  pfjid_pkg::snap_t snap_nxt;

  logic                          snap_free;
  logic                          s1_go;
  logic                          take;
  logic [pfjid_pkg::ETA_W-1:0]   eta_abs;

  // Flow control: a non-last word always drains, a last word needs the snapshot
  assign snap_free = !snap_valid_r || snap_ready;
  assign s1_go     = s1_valid_r && (!s1_last_r || snap_free);
  assign in_stall  = s1_valid_r && !s1_go;

  assign take = s1_has_r && (seen_r < pfjid_pkg::SEEN_W'(pfjid_pkg::MAX_CONSTITUENTS));

  // Sums including the current word
  always_comb begin
    chg_e_nxt   = chg_e_r;
    pho_e_nxt   = pho_e_r;
    neu_e_nxt   = neu_e_r;
    ele_e_nxt   = ele_e_r;
    tot_e_nxt   = tot_e_r;
    cnt_nxt     = cnt_r;
    chg_cnt_nxt = chg_cnt_r;
    seen_nxt    = seen_r;
    if (take) begin
      seen_nxt  = seen_r + pfjid_pkg::SEEN_W'(1);
      tot_e_nxt = pfjid_pkg::sat_add(tot_e_r, s1_energy_r);
      cnt_nxt   = pfjid_pkg::cnt_inc(cnt_r);
      unique case (s1_kind_r)
        pfjid_pkg::KIND_CHARGED: begin
          chg_e_nxt   = pfjid_pkg::sat_add(chg_e_r, s1_energy_r);
          chg_cnt_nxt = pfjid_pkg::cnt_inc(chg_cnt_r);
        end
        pfjid_pkg::KIND_ELECTRON: begin
          ele_e_nxt = pfjid_pkg::sat_add(ele_e_r, s1_energy_r);
        end
        pfjid_pkg::KIND_PHOTON, pfjid_pkg::KIND_FWD_EGAMMA: begin
          pho_e_nxt = pfjid_pkg::sat_add(pho_e_r, s1_energy_r);
        end
        pfjid_pkg::KIND_NEUTRAL, pfjid_pkg::KIND_FWD_HADRON: begin
          neu_e_nxt = pfjid_pkg::sat_add(neu_e_r, s1_energy_r);
        end
        default: begin
        end
      endcase
    end
  end

  // |eta|; the most negative code maps to 512, which still fits
  assign eta_abs = s1_eta_r[pfjid_pkg::ETA_W-1] ? (pfjid_pkg::ETA_W'(0) - s1_eta_r)
                                                 : s1_eta_r;

  // Jet summary for the classifier
  always_comb begin
    snap_nxt.bypass   = s1_pt_r < bypass_pt;
    snap_nxt.fwd      = eta_abs > pfjid_pkg::ETA_W'(eta_boundary);
    snap_nxt.cen      = eta_abs < pfjid_pkg::ETA_W'(eta_boundary);
    snap_nxt.tot_zero = (tot_e_nxt == '0);
    snap_nxt.chg_ok   = (chg_e_nxt != '0) && (chg_cnt_nxt != '0);
    snap_nxt.cnt_ok   = cnt_nxt > pfjid_pkg::CNT_W'(1);
    snap_nxt.neu_e    = neu_e_nxt;
    snap_nxt.pho_e    = pho_e_nxt;
    snap_nxt.ele_e    = ele_e_nxt;
    snap_nxt.tot_e    = tot_e_nxt;
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_has_r    <= in_has_constituent;
      s1_kind_r   <= in_particle_kind;
      s1_energy_r <= in_energy;
      s1_pt_r     <= in_jet_pt;
      s1_eta_r    <= in_jet_eta;
      s1_last_r   <= in_last;
    end
  end

  // Accumulators, cleared after the last word of a jet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_e_r   <= '0;
      pho_e_r   <= '0;
      neu_e_r   <= '0;
      ele_e_r   <= '0;
      tot_e_r   <= '0;
      cnt_r     <= '0;
      chg_cnt_r <= '0;
      seen_r    <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        chg_e_r   <= '0;
        pho_e_r   <= '0;
        neu_e_r   <= '0;
        ele_e_r   <= '0;
        tot_e_r   <= '0;
        cnt_r     <= '0;
        chg_cnt_r <= '0;
        seen_r    <= '0;
      end else begin
        chg_e_r   <= chg_e_nxt;
        pho_e_r   <= pho_e_nxt;
        neu_e_r   <= neu_e_nxt;
        ele_e_r   <= ele_e_nxt;
        tot_e_r   <= tot_e_nxt;
        cnt_r     <= cnt_nxt;
        chg_cnt_r <= chg_cnt_nxt;
        seen_r    <= seen_nxt;
      end
    end
  end

  // Snapshot control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (snap_free) begin
      snap_valid_r <= s1_go && s1_last_r;
    end
  end

  // Snapshot payload
  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

FILE: design/pfjid_classify.sv
// ----------------------------------------------------------------------------
// pfjid_classify
// Fraction cuts by constant cross-multiplication, tier selection and the
// result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfjid_classify (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                snap_valid,
  output logic                                     snap_ready,
  input  wire pfjid_pkg::snap_t                    snap,
  input  wire logic [pfjid_pkg::MINT_W-1:0]        min_tier,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [pfjid_pkg::TIER_W-1:0]             out_tier,
  output logic                                     out_passes
);

  logic                            out_valid_r;
  logic [pfjid_pkg::TIER_W-1:0]    out_tier_r;
  logic                            out_passes_r;
  logic [pfjid_pkg::TIER_W-1:0]    tier_nxt;
  logic                            passes_nxt;

  logic out_free;
  logic ele_ok;
  logic loose, med_ok, tight;

  // num * e < den * t, constant operands fold into shift-adds
  function automatic logic below_cut(input logic [pfjid_pkg::ESUM_W-1:0] e,
                                     input logic [pfjid_pkg::ESUM_W-1:0] t,
                                     input logic [6:0] num,
                                     input logic [6:0] den);
    logic [pfjid_pkg::MUL_W-1:0] lhs;
    logic [pfjid_pkg::MUL_W-1:0] rhs;
    lhs = pfjid_pkg::MUL_W'(e) * pfjid_pkg::MUL_W'(num);
    rhs = pfjid_pkg::MUL_W'(t) * pfjid_pkg::MUL_W'(den);
    return lhs < rhs;
  endfunction

  assign out_free   = !out_valid_r || !out_stall;
  assign snap_ready = out_free;

  // Tier cuts: neutral and photon fractions plus multiplicity, central extras
  assign ele_ok = below_cut(snap.ele_e, snap.tot_e, 7'd100, 7'd99);

  always_comb begin
    loose  = below_cut(snap.neu_e, snap.tot_e, 7'd100, 7'd99) &&
             below_cut(snap.pho_e, snap.tot_e, 7'd100, 7'd99) && snap.cnt_ok &&
             (snap.fwd || (snap.cen && snap.chg_ok && ele_ok));
    med_ok = below_cut(snap.neu_e, snap.tot_e, 7'd100, 7'd95) &&
             below_cut(snap.pho_e, snap.tot_e, 7'd100, 7'd95) && snap.cnt_ok &&
             (snap.fwd || (snap.cen && snap.chg_ok && ele_ok));
    tight  = below_cut(snap.neu_e, snap.tot_e, 7'd10, 7'd9) &&
             below_cut(snap.pho_e, snap.tot_e, 7'd10, 7'd9) && snap.cnt_ok &&
             (snap.fwd || (snap.cen && snap.chg_ok && ele_ok));
  end

  // Tier and pass flag; bypass wins over everything
  always_comb begin
    priority if (snap.bypass) begin
      tier_nxt = pfjid_pkg::TIER_BYPASS;
    end else if (snap.tot_zero) begin
      tier_nxt = pfjid_pkg::TIER_FAIL;
    end else if (loose && med_ok && tight) begin
      tier_nxt = pfjid_pkg::TIER_TIGHT;
    end else if (loose && med_ok) begin
      tier_nxt = pfjid_pkg::TIER_MEDIUM;
    end else if (loose) begin
      tier_nxt = pfjid_pkg::TIER_LOOSE;
    end else begin
      tier_nxt = pfjid_pkg::TIER_FAIL;
    end
    passes_nxt = snap.bypass || (tier_nxt >= pfjid_pkg::TIER_W'(min_tier));
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      out_tier_r   <= tier_nxt;
      out_passes_r <= passes_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_tier   = out_tier_r;
  assign out_passes = out_passes_r;

endmodule

`default_nettype wire

FILE: design/pf_jet_id_classifier_top.sv
// ----------------------------------------------------------------------------
// pf_jet_id_classifier_top
// Particle-flow jet identification: accumulates constituent energies per jet
// and gives a tier (fail to tight, or bypass) and pass flag on each jet's last word.
// ----------------------------------------------------------------------------
// Throughput: one input word per clock, sustained, while out_stall is low.
// Result path: a jet's last word passes through the input register, the jet
//   snapshot and the result register before its result word is presented.
// Reset: rst_n low at a clock edge empties all stages, clears the running
//   sums and restores bypass_pt 40, eta_boundary 240, min_tier 1.
`default_nettype none

module pf_jet_id_classifier_top (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // input channel
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic                                    in_has_constituent,
  input  wire logic [2:0]                              in_particle_kind,
  input  wire logic [pfjid_pkg::E_W-1:0]               in_energy,
  input  wire logic [pfjid_pkg::PT_W-1:0]              in_jet_pt,
  input  wire logic signed [pfjid_pkg::ETA_W-1:0]      in_jet_eta,
  input  wire logic                                    in_last,
  // result channel
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [pfjid_pkg::TIER_W-1:0]                 out_tier,
  output logic                                         out_passes,
  // configuration write channel
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [pfjid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [pfjid_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [pfjid_pkg::PT_W-1:0]   bypass_pt_r;
  logic [pfjid_pkg::BND_W-1:0]  eta_boundary_r;
  logic [pfjid_pkg::MINT_W-1:0] min_tier_r;

  logic             snap_valid;
  logic             snap_ready;
  pfjid_pkg::snap_t snap;

  // Configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_pt_r    <= pfjid_pkg::BYPASS_PT_RST;
      eta_boundary_r <= pfjid_pkg::ETA_BOUNDARY_RST;
      min_tier_r     <= pfjid_pkg::MIN_TIER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfjid_pkg::CFG_BYPASS_PT:    bypass_pt_r    <= cfg_data[pfjid_pkg::PT_W-1:0];
        pfjid_pkg::CFG_ETA_BOUNDARY: eta_boundary_r <= cfg_data[pfjid_pkg::BND_W-1:0];
        pfjid_pkg::CFG_MIN_TIER:     min_tier_r     <= cfg_data[pfjid_pkg::MINT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Running sums and jet snapshot
  pfjid_accum u_accum (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_has_constituent (in_has_constituent),
    .in_particle_kind   (in_particle_kind),
    .in_energy          (in_energy),
    .in_jet_pt          (in_jet_pt),
    .in_jet_eta         (in_jet_eta),
    .in_last            (in_last),
    .bypass_pt          (bypass_pt_r),
    .eta_boundary       (eta_boundary_r),
    .snap_valid         (snap_valid),
    .snap_ready         (snap_ready),
    .snap               (snap)
  );

  // Cuts and result register
  pfjid_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .min_tier   (min_tier_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tier   (out_tier),
    .out_passes (out_passes)
  );

endmodule

`default_nettype wire
